>>> design/sync_len_crc_frame_parser_defines.svh
// Assertion macros for the sync/length/CRC frame parser.
// Included by the top level; every macro samples on clock and is disabled by reset.
`ifndef SYNC_LEN_CRC_FRAME_PARSER_DEFINES_SVH
`define SYNC_LEN_CRC_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication between two conditions.
`define SLCFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Delayed implication: the consequent is checked later than the antecedent.
`define SLCFP_ASSERT_LATER(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

>>> design/slcfp_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the frame parser.
// No dependencies; used by every other file of the block but the assertion macro header.
package slcfp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BODY_LEN = 2'd2;

   localparam logic [7:0]  SYNC_FIRST_RESET   = 8'd170;
   localparam logic [7:0]  SYNC_SECOND_RESET  = 8'd85;
   localparam logic [15:0] MAX_BODY_LEN_RESET = 16'd512;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [3:0] {
      PH_SYNC0 = 4'd0,
      PH_SYNC1 = 4'd1,
      PH_CMD   = 4'd2,
      PH_SEQ   = 4'd3,
      PH_LENL  = 4'd4,
      PH_LENH  = 4'd5,
      PH_BODY  = 4'd6,
      PH_CRCL  = 4'd7,
      PH_CRCH  = 4'd8,
      PH_SKIP  = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      ST_INCOMPLETE = 3'd0,
      ST_BAD_SYNC   = 3'd1,
      ST_OK         = 3'd2,
      ST_CRC_ERR    = 3'd3,
      ST_LEN_ERR    = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       match_first;
      logic       match_second;
   } qitem_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  frame_cmd;
      logic [7:0]  frame_seq;
      logic [15:0] frame_len;
      logic [7:0]  body_byte;
      logic        body_valid;
   } result_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> design/slcfp_front.sv
// Front end: accepts input items, tags each byte with its sync matches and queues it.
// Depends on slcfp_pkg for the queue item type and depth.
module slcfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic [7:0]            sync_first,
   input  logic [7:0]            sync_second,
   output logic                  q_valid,
   output slcfp_pkg::qitem_type  q_item,
   input  logic                  q_pop
);

   slcfp_pkg::qitem_type                 store_ff [slcfp_pkg::QUEUE_DEPTH];
   logic [slcfp_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [slcfp_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [slcfp_pkg::QCNT_W-1:0]         count_ff, count_in;
   slcfp_pkg::qitem_type                 tag_item;
   logic                                 push;

   assign req_stall = (count_ff == slcfp_pkg::QCNT_W'(slcfp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = store_ff[rd_ptr_ff];

   always_comb begin
      tag_item.data_byte    = req_data_byte;
      tag_item.match_first  = (req_data_byte == sync_first);
      tag_item.match_second = (req_data_byte == sync_second);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == slcfp_pkg::QPTR_W'(slcfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == slcfp_pkg::QPTR_W'(slcfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= tag_item;
      end
   end

endmodule

>>> design/slcfp_back.sv
// Back end: frame state machine with bytewise CRC and the registered result stage.
// Depends on slcfp_pkg for phase, status and item types and the CRC update.
module slcfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  slcfp_pkg::qitem_type  q_item,
   output logic                  q_pop,
   input  logic [15:0]           max_body_len,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slcfp_pkg::result_type rsp_result
);

   slcfp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [7:0]            seq_ff, seq_in;
   logic [15:0]           len_ff, len_in;
   logic [15:0]           count_ff, count_in;
   logic [7:0]            crc_lo_ff, crc_lo_in;
   logic [16:0]           skip_ff, skip_in;
   logic [15:0]           crc_ff, crc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   slcfp_pkg::result_type result_ff, result_in;

   logic [7:0]            b;
   logic [15:0]           crc_next;
   logic [15:0]           len_full;
   logic [15:0]           count_inc;
   logic [16:0]           skip_dec;
   logic                  frame_end;

   assign q_pop      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign b         = q_item.data_byte;
   assign crc_next  = slcfp_pkg::crc16_update(crc_ff, b);
   assign len_full  = {b, len_ff[7:0]};
   assign count_inc = count_ff + 16'd1;
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 17'd1 : skip_ff;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crc_lo_in = crc_lo_ff;
      skip_in   = skip_ff;
      crc_in    = crc_ff;
      frame_end = 1'b0;
      result_in = '{status: slcfp_pkg::ST_INCOMPLETE, default: '0};
      case (phase_ff)
         slcfp_pkg::PH_SYNC0: begin
            if (q_item.match_first) begin
               phase_in = slcfp_pkg::PH_SYNC1;
            end
         end
         slcfp_pkg::PH_SYNC1: begin
            if (q_item.match_second) begin
               phase_in = slcfp_pkg::PH_CMD;
               crc_in   = slcfp_pkg::CRC_INIT;
            end else begin
               phase_in = q_item.match_first ? slcfp_pkg::PH_SYNC1 : slcfp_pkg::PH_SYNC0;
               result_in.status = slcfp_pkg::ST_BAD_SYNC;
            end
         end
         slcfp_pkg::PH_CMD: begin
            cmd_in   = b;
            crc_in   = crc_next;
            phase_in = slcfp_pkg::PH_SEQ;
         end
         slcfp_pkg::PH_SEQ: begin
            seq_in   = b;
            crc_in   = crc_next;
            phase_in = slcfp_pkg::PH_LENL;
         end
         slcfp_pkg::PH_LENL: begin
            len_in   = {8'h00, b};
            crc_in   = crc_next;
            phase_in = slcfp_pkg::PH_LENH;
         end
         slcfp_pkg::PH_LENH: begin
            len_in   = len_full;
            crc_in   = crc_next;
            count_in = '0;
            if (len_full > max_body_len) begin
               skip_in  = {1'b0, len_full} + 17'd2;
               phase_in = slcfp_pkg::PH_SKIP;
            end else if (len_full == '0) begin
               phase_in = slcfp_pkg::PH_CRCL;
            end else begin
               phase_in = slcfp_pkg::PH_BODY;
            end
         end
         slcfp_pkg::PH_BODY: begin
            crc_in               = crc_next;
            count_in             = count_inc;
            result_in.body_byte  = b;
            result_in.body_valid = 1'b1;
            if (count_inc >= len_ff) begin
               phase_in = slcfp_pkg::PH_CRCL;
            end
         end
         slcfp_pkg::PH_CRCL: begin
            crc_lo_in = b;
            phase_in  = slcfp_pkg::PH_CRCH;
         end
         slcfp_pkg::PH_CRCH: begin
            result_in.frame_cmd = cmd_ff;
            result_in.frame_seq = seq_ff;
            result_in.frame_len = len_ff;
            result_in.status    = ({b, crc_lo_ff} == crc_ff) ?
                                  slcfp_pkg::ST_OK : slcfp_pkg::ST_CRC_ERR;
            frame_end = 1'b1;
         end
         slcfp_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               result_in.frame_cmd = cmd_ff;
               result_in.frame_seq = seq_ff;
               result_in.status    = slcfp_pkg::ST_LEN_ERR;
               frame_end = 1'b1;
            end
         end
         default: begin
            result_in.status = slcfp_pkg::ST_BAD_SYNC;
            frame_end = 1'b1;
         end
      endcase
      if (frame_end) begin
         phase_in  = slcfp_pkg::PH_SYNC0;
         cmd_in    = '0;
         seq_in    = '0;
         len_in    = '0;
         count_in  = '0;
         crc_lo_in = '0;
         skip_in   = '0;
         crc_in    = slcfp_pkg::CRC_INIT;
      end
   end

   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= slcfp_pkg::PH_SYNC0;
         cmd_ff       <= '0;
         seq_ff       <= '0;
         len_ff       <= '0;
         count_ff     <= '0;
         crc_lo_ff    <= '0;
         skip_ff      <= '0;
         crc_ff       <= slcfp_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff  <= phase_in;
            cmd_ff    <= cmd_in;
            seq_ff    <= seq_in;
            len_ff    <= len_in;
            count_ff  <= count_in;
            crc_lo_ff <= crc_lo_in;
            skip_ff   <= skip_in;
            crc_ff    <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

>>> design/sync_len_crc_frame_parser.sv
// Frame parser top level: one result item per input byte, passing through the queue and
// the result register; one item per cycle sustained while rsp_stall is low.
// A two-entry queue decouples the front end from the back end and its result register.
// Synchronous active-high reset restores the sync bytes to 170 and 85, the length limit
// to 512, empties the queue and returns the parser to the hunt for the first sync byte.
`include "sync_len_crc_frame_parser_defines.svh"
module sync_len_crc_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [7:0]                        rsp_frame_cmd,
   output logic [7:0]                        rsp_frame_seq,
   output logic [15:0]                       rsp_frame_len,
   output logic [7:0]                        rsp_body_byte,
   output logic                              rsp_body_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slcfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slcfp_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [7:0]            sync_first_ff;
   logic [7:0]            sync_second_ff;
   logic [15:0]           max_body_len_ff;
   logic                  q_valid;
   logic                  q_pop;
   slcfp_pkg::qitem_type  q_item;
   slcfp_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= slcfp_pkg::SYNC_FIRST_RESET;
         sync_second_ff  <= slcfp_pkg::SYNC_SECOND_RESET;
         max_body_len_ff <= slcfp_pkg::MAX_BODY_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            slcfp_pkg::REG_SYNC_FIRST:   sync_first_ff   <= csr_data[7:0];
            slcfp_pkg::REG_SYNC_SECOND:  sync_second_ff  <= csr_data[7:0];
            slcfp_pkg::REG_MAX_BODY_LEN: max_body_len_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   slcfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .sync_first    (sync_first_ff),
      .sync_second   (sync_second_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   slcfp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .max_body_len (max_body_len_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (result)
   );

   assign rsp_status     = result.status;
   assign rsp_frame_cmd  = result.frame_cmd;
   assign rsp_frame_seq  = result.frame_seq;
   assign rsp_frame_len  = result.frame_len;
   assign rsp_body_byte  = result.body_byte;
   assign rsp_body_valid = result.body_valid;

   `SLCFP_ASSERT_NOW(a_body_incomplete, rsp_valid && rsp_body_valid, rsp_status == slcfp_pkg::ST_INCOMPLETE, "Body item carries a final status.")
   `SLCFP_ASSERT_NOW(a_len_on_end, rsp_valid && (rsp_frame_len != 16'd0), (rsp_status == slcfp_pkg::ST_OK) || (rsp_status == slcfp_pkg::ST_CRC_ERR), "Frame length shown without a CRC verdict.")
   `SLCFP_ASSERT_NOW(a_body_byte_gated, rsp_valid && !rsp_body_valid, rsp_body_byte == 8'd0, "Body byte set on a non-body item.")
   `SLCFP_ASSERT_LATER(a_result_follows, req_valid && !req_stall, rsp_valid, "Accepted item produced no result in time.")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sync_len_crc_frame_parser: one status item is expected per byte.
// Depends on slcfp_pkg and the design files. A predictor inside the bench follows the parser.
module tb;

   localparam logic [slcfp_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD} row_kind_type;
   typedef enum {FR_CLEAN, FR_BAD_CRC, FR_CUT} frame_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [7:0]            data;
      bit                    typed;
      slcfp_pkg::result_type want;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic [7:0]                       req_data_byte = 8'h00;
   logic                             rsp_stall = 1'b0;
   logic                             csr_valid = 1'b0;
   logic [slcfp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [slcfp_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic                             req_stall;
   logic                             rsp_valid;
   logic [2:0]                       rsp_status;
   logic [7:0]                       rsp_frame_cmd;
   logic [7:0]                       rsp_frame_seq;
   logic [15:0]                      rsp_frame_len;
   logic [7:0]                       rsp_body_byte;
   logic                             rsp_body_valid;
   logic                             csr_ready;

   sync_len_crc_frame_parser uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_frame_cmd  (rsp_frame_cmd),
      .rsp_frame_seq  (rsp_frame_seq),
      .rsp_frame_len  (rsp_frame_len),
      .rsp_body_byte  (rsp_body_byte),
      .rsp_body_valid (rsp_body_valid),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [7:0]           sync_a = slcfp_pkg::SYNC_FIRST_RESET;
   logic [7:0]           sync_b = slcfp_pkg::SYNC_SECOND_RESET;
   logic [15:0]          max_len = slcfp_pkg::MAX_BODY_LEN_RESET;
   slcfp_pkg::phase_type prs_phase;
   logic [7:0]           prs_cmd;
   logic [7:0]           prs_seq;
   logic [15:0]          prs_len;
   logic [15:0]          prs_count;
   logic [7:0]           prs_crc_lo;
   logic [16:0]          prs_skip;
   logic [15:0]          prs_crc;

   slcfp_pkg::result_type expected_results[$];
   stim_row_type          directed_rows[$];
   int                    errors = 0;
   int                    items_sent = 0;
   int                    gap_pct = 0;
   int                    stall_pct = 0;
   int                    stall_left = 0;

   function automatic logic [15:0] modbus_byte(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ d[i];
         r = r >> 1;
         if (fb) r = r ^ slcfp_pkg::CRC_POLY;
      end
      return r;
   endfunction

   function automatic void frame_reset();
      prs_phase = slcfp_pkg::PH_SYNC0;
      prs_cmd = 8'h00;
      prs_seq = 8'h00;
      prs_len = 16'h0000;
      prs_count = 16'h0000;
      prs_crc_lo = 8'h00;
      prs_skip = 17'h00000;
      prs_crc = slcfp_pkg::CRC_INIT;
   endfunction

   function automatic slcfp_pkg::result_type parse_byte(input logic [7:0] b);
      slcfp_pkg::result_type r;
      r = '0;
      r.status = slcfp_pkg::ST_INCOMPLETE;
      case (prs_phase)
         slcfp_pkg::PH_SYNC0: begin
            if (b == sync_a) prs_phase = slcfp_pkg::PH_SYNC1;
         end
         slcfp_pkg::PH_SYNC1: begin
            if (b == sync_b) begin
               prs_phase = slcfp_pkg::PH_CMD;
               prs_crc = slcfp_pkg::CRC_INIT;
            end else begin
               prs_phase = (b == sync_a) ? slcfp_pkg::PH_SYNC1 : slcfp_pkg::PH_SYNC0;
               r.status = slcfp_pkg::ST_BAD_SYNC;
            end
         end
         slcfp_pkg::PH_CMD: begin
            prs_cmd = b;
            prs_crc = modbus_byte(prs_crc, b);
            prs_phase = slcfp_pkg::PH_SEQ;
         end
         slcfp_pkg::PH_SEQ: begin
            prs_seq = b;
            prs_crc = modbus_byte(prs_crc, b);
            prs_phase = slcfp_pkg::PH_LENL;
         end
         slcfp_pkg::PH_LENL: begin
            prs_len = {8'h00, b};
            prs_crc = modbus_byte(prs_crc, b);
            prs_phase = slcfp_pkg::PH_LENH;
         end
         slcfp_pkg::PH_LENH: begin
            prs_len[15:8] = b;
            prs_crc = modbus_byte(prs_crc, b);
            prs_count = 16'h0000;
            if (prs_len > max_len) begin
               prs_skip = {1'b0, prs_len} + 17'd2;
               prs_phase = slcfp_pkg::PH_SKIP;
            end else if (prs_len == 16'h0000) begin
               prs_phase = slcfp_pkg::PH_CRCL;
            end else begin
               prs_phase = slcfp_pkg::PH_BODY;
            end
         end
         slcfp_pkg::PH_BODY: begin
            prs_crc = modbus_byte(prs_crc, b);
            r.body_byte = b;
            r.body_valid = 1'b1;
            prs_count = prs_count + 16'd1;
            if (prs_count >= prs_len) prs_phase = slcfp_pkg::PH_CRCL;
         end
         slcfp_pkg::PH_CRCL: begin
            prs_crc_lo = b;
            prs_phase = slcfp_pkg::PH_CRCH;
         end
         slcfp_pkg::PH_CRCH: begin
            r.frame_cmd = prs_cmd;
            r.frame_seq = prs_seq;
            r.frame_len = prs_len;
            r.status = ({b, prs_crc_lo} == prs_crc) ? slcfp_pkg::ST_OK : slcfp_pkg::ST_CRC_ERR;
            frame_reset();
         end
         slcfp_pkg::PH_SKIP: begin
            if (prs_skip != 17'd0) prs_skip = prs_skip - 17'd1;
            if (prs_skip == 17'd0) begin
               r.frame_cmd = prs_cmd;
               r.frame_seq = prs_seq;
               r.status = slcfp_pkg::ST_LEN_ERR;
               frame_reset();
            end
         end
         default: begin
            frame_reset();
            r.status = slcfp_pkg::ST_BAD_SYNC;
         end
      endcase
      return r;
   endfunction

   function automatic void add_row(input row_kind_type k, input logic [7:0] d, input bit t,
                                   input slcfp_pkg::status_type s, input logic [7:0] c,
                                   input logic [7:0] q, input logic [15:0] l,
                                   input logic [7:0] bb, input logic v);
      stim_row_type row;
      row.kind = k;
      row.data = d;
      row.typed = t;
      row.want.status = s;
      row.want.frame_cmd = c;
      row.want.frame_seq = q;
      row.want.frame_len = l;
      row.want.body_byte = bb;
      row.want.body_valid = v;
      directed_rows.push_back(row);
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input slcfp_pkg::result_type want);
      slcfp_pkg::result_type pred;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      pred = parse_byte(b);
      expected_results.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic send_raw(input logic [7:0] b);
      send_byte(b, 1'b0, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [slcfp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slcfp_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         slcfp_pkg::REG_SYNC_FIRST:   sync_a = val[7:0];
         slcfp_pkg::REG_SYNC_SECOND:  sync_b = val[7:0];
         slcfp_pkg::REG_MAX_BODY_LEN: max_len = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic start_phase(input logic [7:0] a, input logic [7:0] b, input logic [15:0] m,
                              input int g, input int s);
      logic [7:0] junk;
      settle();
      junk = 8'($urandom);
      write_reg(slcfp_pkg::REG_SYNC_FIRST, {junk, a});
      write_reg(slcfp_pkg::REG_SYNC_SECOND, {~junk, b});
      write_reg(slcfp_pkg::REG_MAX_BODY_LEN, m);
      write_reg(REG_UNUSED, {junk, ~junk});
      gap_pct = g;
      stall_pct = s;
   endtask

   task automatic send_frame(input logic [15:0] len, input frame_kind_type fk);
      logic [7:0]  bytes_q[$];
      logic [7:0]  d;
      logic [15:0] crc;
      int          cut;
      bytes_q.push_back(sync_a);
      bytes_q.push_back(sync_b);
      d = 8'($urandom);
      bytes_q.push_back(d);
      d = 8'($urandom);
      bytes_q.push_back(d);
      bytes_q.push_back(len[7:0]);
      bytes_q.push_back(len[15:8]);
      crc = slcfp_pkg::CRC_INIT;
      for (int i = 2; i < 6; i++) crc = modbus_byte(crc, bytes_q[i]);
      if (len > max_len) begin
         for (int i = 0; i < len + 2; i++) begin
            d = 8'($urandom);
            bytes_q.push_back(d);
         end
      end else begin
         for (int i = 0; i < len; i++) begin
            d = 8'($urandom);
            crc = modbus_byte(crc, d);
            bytes_q.push_back(d);
         end
         if (fk == FR_BAD_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
         bytes_q.push_back(crc[7:0]);
         bytes_q.push_back(crc[15:8]);
      end
      if (fk == FR_CUT) begin
         // Cut only where the parser falls back into the sync hunt within a bounded count.
         if (sync_a != sync_b && $urandom_range(0, 3) == 0) cut = 1;
         else cut = $urandom_range(6, bytes_q.size() - 1);
         while (bytes_q.size() > cut) void'(bytes_q.pop_back());
      end
      foreach (bytes_q[i]) send_raw(bytes_q[i]);
   endtask

   task automatic random_frame();
      int             pick;
      int             lim;
      int             n;
      logic [7:0]     junk;
      logic [15:0]    len;
      frame_kind_type fk;
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n; i++) begin
         junk = 8'($urandom);
         if (sync_a != sync_b && $urandom_range(0, 2) == 0) junk = sync_a;
         else while (junk == sync_a || junk == sync_b) junk = 8'($urandom);
         send_raw(junk);
      end
      if (pick < 15 && max_len < 16'd64) begin
         len = 16'(max_len + $urandom_range(1, 5));
      end else if (pick < 25 && max_len <= 16'd48) begin
         len = max_len;
      end else begin
         if (max_len < 16'd12) lim = int'(max_len);
         else lim = 12;
         if ($urandom_range(0, 15) == 0 && max_len >= 16'd48) lim = 48;
         len = 16'($urandom_range(0, lim));
      end
      fk = (pick >= 90) ? FR_CUT : (pick >= 78) ? FR_BAD_CRC : FR_CLEAN;
      send_frame(len, fk);
      if ($urandom_range(0, 24) == 0) settle();
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      slcfp_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("frame_cmd", 16'(want.frame_cmd), 16'(rsp_frame_cmd));
            check_field("frame_seq", 16'(want.frame_seq), 16'(rsp_frame_seq));
            check_field("frame_len", want.frame_len, rsp_frame_len);
            check_field("body_byte", 16'(want.body_byte), 16'(rsp_body_byte));
            check_field("body_valid", 16'(want.body_valid), 16'(rsp_body_valid));
         end
      end
   end

   initial begin
      #1000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      stim_row_type row;
      logic [7:0]   d;
      logic [7:0]   ra;
      logic [7:0]   rb;
      logic [15:0]  rm;
      int           mark;
      frame_reset();
      add_row(ROW_BYTE, 8'hAA, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h12, 1'b1, slcfp_pkg::ST_BAD_SYNC, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'hAA, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'hAA, 1'b1, slcfp_pkg::ST_BAD_SYNC, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h55, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'hFF, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_CRC_LO, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00,
              1'b0);
      add_row(ROW_CRC_HI, 8'h00, 1'b1, slcfp_pkg::ST_OK, 8'hFF, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'hAA, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h55, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'hFF, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h01, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
      add_row(ROW_BYTE, 8'h00, 1'b1, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b1);
      add_row(ROW_CRC_LO, 8'h00, 1'b0, slcfp_pkg::ST_INCOMPLETE, 8'h00, 8'h00, 16'd0, 8'h00,
              1'b0);
      add_row(ROW_CRC_BAD, 8'h00, 1'b1, slcfp_pkg::ST_CRC_ERR, 8'h00, 8'hFF, 16'd1, 8'h00, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 20;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_CRC_LO:  d = prs_crc[7:0];
            ROW_CRC_HI:  d = prs_crc[15:8];
            ROW_CRC_BAD: d = ~prs_crc[15:8];
            default:     d = row.data;
         endcase
         send_byte(d, row.typed, row.want);
      end
      // One byte over the reset length limit must be skipped as a length error.
      send_frame(16'd513, FR_CLEAN);

      for (int p = 0; p < 8; p++) begin
         ra = 8'($urandom);
         rb = 8'($urandom);
         rm = (p == 4) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(1000, 65534));
         case (p)
            0: start_phase(8'hAA, 8'h55, 16'd16, 20, 20);
            1: start_phase(8'h00, 8'hFF, 16'd0, 30, 10);
            2: start_phase(8'hFF, 8'h00, 16'hFFFF, 10, 30);
            3: start_phase(8'h5A, 8'h5A, 16'd8, 20, 20);
            4: start_phase(ra, rb, rm, 0, 0);
            5: start_phase(8'h00, 8'h00, 16'd3, 40, 40);
            6: start_phase(8'hFF, 8'hFF, rm, 15, 15);
            default: start_phase(ra, rb, 16'hFFFE, 0, 0);
         endcase
         mark = items_sent;
         while (items_sent - mark < 30) random_frame();
      end

      // The largest length needs a skip count one bit wider than the length, so the
      // frame is still being skipped when the run ends.
      d = 8'($urandom);
      while (d == sync_a || d == sync_b) d = 8'($urandom);
      while (prs_phase != slcfp_pkg::PH_SYNC0) send_raw(d);
      send_raw(sync_a);
      send_raw(sync_b);
      send_raw(8'($urandom));
      send_raw(8'($urandom));
      send_raw(8'hFF);
      send_raw(8'hFF);
      repeat (20) send_raw(8'($urandom));

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/slcfp_pkg.sv
design/slcfp_front.sv
design/slcfp_back.sv
design/sync_len_crc_frame_parser.sv
dv/tb.sv
